/* hw/rtl/sas_pkg.sv */
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the sprite animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int MAX_SETS    = 8;
	localparam int MAX_FRAMES  = 16;
	localparam int SET_W       = $clog2(MAX_SETS);
	localparam int FRAME_W     = $clog2(MAX_FRAMES);
	localparam int CNT_W       = $clog2(MAX_SETS + 1);
	localparam int LEN_W       = 5;
	localparam int WEIGHT_W    = 8;
	localparam int DELAY_W     = 16;
	localparam int TIME_W      = 32;
	localparam int RND_W       = 16;
	localparam int SUM_W       = $clog2(MAX_SETS * ((1 << WEIGHT_W) - 1) + 1);
	localparam int DIV_CNT_W   = $clog2(RND_W);
	localparam int DLY_ADDR_W  = SET_W + FRAME_W;
	localparam int DLY_DEPTH   = MAX_SETS * MAX_FRAMES;
	localparam int CMD_W       = 3;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = CFG_IDX_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_PLAY       = 3'd1,
		CMD_PAUSE      = 3'd2,
		CMD_RESET      = 3'd3,
		CMD_LOAD_SET   = 3'd4,
		CMD_LOAD_DELAY = 3'd5
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE   = 2'd0,
		MODE_ONCE   = 2'd1,
		MODE_LOOP   = 2'd2,
		MODE_RANDOM = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LATCH,
		OP_STOP,
		OP_RESET,
		OP_LOAD_SET,
		OP_LOAD_DELAY,
		OP_ADV_FRAME,
		OP_END_HALT,
		OP_END_NEXT,
		OP_END_STOP,
		OP_END_PICK,
		OP_SUM_INIT,
		OP_SUM_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_WALK_STEP,
		OP_START,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} sas_ctl_t;

	typedef struct packed {
		cmd_t  cmd;
		mode_t mode;
		logic  tick_go;
		logic  set_end;
		logic  last_set;
		logic  sum_done;
		logic  sum_zero;
		logic  div_done;
		logic  walk_go;
	} sas_stat_t;

endpackage

/* hw/rtl/sas_ctrl.sv */
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencing state machine: decodes the request, steps the weighted pick and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module sas_ctrl
	import sas_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  sas_stat_t stat,
	output sas_ctl_t  ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SUM,
		S_DIV,
		S_WALK,
		S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	dp_op_t op;

	always_comb begin
		op      = OP_IDLE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LATCH;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				unique case (stat.cmd)
					CMD_TICK: begin
						if (stat.tick_go && !stat.set_end) begin
							op = OP_ADV_FRAME;
						end else if (stat.tick_go) begin
							unique case (stat.mode)
								MODE_ONCE:   op = stat.last_set ? OP_END_HALT : OP_END_NEXT;
								MODE_LOOP:   op = OP_END_NEXT;
								MODE_RANDOM: begin
									op      = OP_END_PICK;
									state_d = S_SUM;
								end
								default:     op = OP_END_STOP;
							endcase
						end
					end
					CMD_PLAY: begin
						unique case (stat.mode)
							MODE_NONE:   op = OP_STOP;
							MODE_RANDOM: begin
								op      = OP_SUM_INIT;
								state_d = S_SUM;
							end
							default:     op = OP_START;
						endcase
					end
					CMD_PAUSE:      op = OP_STOP;
					CMD_RESET:      op = OP_RESET;
					CMD_LOAD_SET:   op = OP_LOAD_SET;
					CMD_LOAD_DELAY: op = OP_LOAD_DELAY;
					default:        op = OP_IDLE;
				endcase
			end
			S_SUM: begin
				if (!stat.sum_done) begin
					op = OP_SUM_STEP;
				end else if (stat.sum_zero) begin
					op      = OP_START;
					state_d = S_OUT;
				end else begin
					op      = OP_DIV_INIT;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				op = OP_DIV_STEP;
				if (stat.div_done) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.walk_go) begin
					op = OP_WALK_STEP;
				end else begin
					op      = OP_START;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ctl.op    = op;

endmodule

/* hw/rtl/sas_dp.sv */
// ----------------------------------------------------------------------------
// sas_dp
// Datapath: set tables, frame delay memory, playback state, weight sum,
// bit-serial remainder and cumulative weight walk, output register.
// ----------------------------------------------------------------------------
module sas_dp
	import sas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  sas_ctl_t              ctl,
	output sas_stat_t             stat,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [RND_W-1:0]      random_value,
	input  logic [SET_W-1:0]      set_index,
	input  logic [FRAME_W-1:0]    frame_index,
	input  logic [WEIGHT_W-1:0]   priority_req,
	input  logic [LEN_W-1:0]      frame_count,
	input  logic [DELAY_W-1:0]    delay_ms,
	output logic [SET_W-1:0]      current_set,
	output logic [FRAME_W-1:0]    current_frame,
	output logic                  playing,
	output logic                  frame_changed
);

	logic [WEIGHT_W-1:0] weight_mem [MAX_SETS];
	logic [LEN_W-1:0]    length_mem [MAX_SETS];
	logic [DELAY_W-1:0]  delay_mem  [DLY_DEPTH];

	mode_t               anim_mode_q;
	logic [CNT_W-1:0]    set_count_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [TIME_W-1:0]   now_q;
	logic [RND_W-1:0]    rnd_q;
	logic [SET_W-1:0]    set_idx_q;
	logic [FRAME_W-1:0]  frame_idx_q;
	logic [WEIGHT_W-1:0] prio_q;
	logic [LEN_W-1:0]    fcount_q;
	logic [DELAY_W-1:0]  delay_q;

	logic [SET_W-1:0]    set_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                running_q;
	logic [TIME_W-1:0]   last_q;
	logic                changed_q;

	logic [CNT_W-1:0]    idx_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    cum_q;
	logic [SUM_W-1:0]    rem_q;
	logic [RND_W-1:0]    dvd_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [DELAY_W-1:0]  delay_rd_q;

	logic [SET_W-1:0]    out_set_q;
	logic [FRAME_W-1:0]  out_frame_q;
	logic                out_playing_q;
	logic                out_changed_q;

	logic [CNT_W-1:0]    sets_n;
	logic [WEIGHT_W-1:0] w_rd;
	logic [LEN_W-1:0]    len_rd;
	logic [LEN_W-1:0]    frame_next;
	logic [CNT_W-1:0]    set_next;
	logic [TIME_W-1:0]   elapsed;
	logic [SUM_W:0]      div_try;
	logic [SUM_W:0]      div_sub;
	logic [SUM_W-1:0]    w_ext;
	logic [SET_W-1:0]    set_adv;

	always_comb begin
		if (set_count_q == '0) begin
			sets_n = CNT_W'(1);
		end else if (set_count_q > CNT_W'(MAX_SETS)) begin
			sets_n = CNT_W'(MAX_SETS);
		end else begin
			sets_n = set_count_q;
		end
	end

	assign w_rd       = weight_mem[idx_q[SET_W-1:0]];
	assign w_ext      = SUM_W'(w_rd);
	assign len_rd     = length_mem[set_q];
	assign frame_next = LEN_W'(frame_q) + LEN_W'(1);
	assign set_next   = CNT_W'(set_q) + CNT_W'(1);
	assign set_adv    = (set_next >= sets_n) ? '0 : set_next[SET_W-1:0];
	assign elapsed    = now_q - last_q;
	assign div_try    = {rem_q, dvd_q[RND_W-1]};
	assign div_sub    = div_try - {1'b0, sum_q};

	assign stat.cmd      = cmd_t'(cmd_q);
	assign stat.mode     = anim_mode_q;
	assign stat.tick_go  = running_q && (TIME_W'(delay_rd_q) < elapsed);
	assign stat.set_end  = (frame_next >= len_rd) || (frame_next >= LEN_W'(MAX_FRAMES));
	assign stat.last_set = (set_next >= sets_n);
	assign stat.sum_done = (idx_q == sets_n);
	assign stat.sum_zero = (sum_q == '0);
	assign stat.div_done = (dcnt_q == DIV_CNT_W'(RND_W - 1));
	assign stat.walk_go  = (cum_q < rem_q) && (idx_q < sets_n);

	// configuration and playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anim_mode_q <= MODE_LOOP;
			set_count_q <= CNT_W'(1);
			set_q       <= '0;
			frame_q     <= '0;
			running_q   <= 1'b0;
			last_q      <= '0;
			changed_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ANIM_MODE: anim_mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
					CFG_SET_COUNT: set_count_q <= cfg_data[CNT_W-1:0];
					default:       ;
				endcase
			end
			unique case (ctl.op)
				OP_LATCH:  changed_q <= 1'b0;
				OP_STOP:   running_q <= 1'b0;
				OP_RESET: begin
					running_q <= 1'b0;
					frame_q   <= '0;
				end
				OP_ADV_FRAME: begin
					frame_q   <= frame_next[FRAME_W-1:0];
					last_q    <= now_q;
					changed_q <= 1'b1;
				end
				OP_END_HALT: begin
					set_q     <= '0;
					running_q <= 1'b0;
					frame_q   <= '0;
					last_q    <= now_q;
					changed_q <= 1'b1;
				end
				OP_END_NEXT: begin
					set_q     <= set_adv;
					running_q <= 1'b1;
					frame_q   <= '0;
					last_q    <= now_q;
					changed_q <= 1'b1;
				end
				OP_END_STOP: begin
					running_q <= 1'b0;
					frame_q   <= '0;
					last_q    <= now_q;
					changed_q <= 1'b1;
				end
				OP_END_PICK: begin
					frame_q   <= '0;
					last_q    <= now_q;
					changed_q <= 1'b1;
				end
				OP_WALK_STEP: set_q <= idx_q[SET_W-1:0];
				OP_START: begin
					running_q <= 1'b1;
					last_q    <= now_q;
				end
				default: ;
			endcase
		end
	end

	// request fields, pick scratch and result register
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LATCH: begin
				cmd_q       <= cmd;
				now_q       <= now_ms;
				rnd_q       <= random_value;
				set_idx_q   <= set_index;
				frame_idx_q <= frame_index;
				prio_q      <= priority_req;
				fcount_q    <= frame_count;
				delay_q     <= delay_ms;
			end
			OP_END_PICK, OP_SUM_INIT: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			OP_SUM_STEP: begin
				sum_q <= sum_q + w_ext;
				idx_q <= idx_q + CNT_W'(1);
			end
			OP_DIV_INIT: begin
				rem_q  <= '0;
				dvd_q  <= rnd_q;
				dcnt_q <= '0;
				idx_q  <= '0;
				cum_q  <= '0;
			end
			OP_DIV_STEP: begin
				if (div_try >= {1'b0, sum_q}) begin
					rem_q <= div_sub[SUM_W-1:0];
				end else begin
					rem_q <= div_try[SUM_W-1:0];
				end
				dvd_q  <= {dvd_q[RND_W-2:0], 1'b0};
				dcnt_q <= dcnt_q + DIV_CNT_W'(1);
			end
			OP_WALK_STEP: begin
				cum_q <= cum_q + w_ext;
				idx_q <= idx_q + CNT_W'(1);
			end
			OP_OUT: begin
				out_set_q     <= set_q;
				out_frame_q   <= frame_q;
				out_playing_q <= running_q;
				out_changed_q <= changed_q;
			end
			default: ;
		endcase
	end

	// set tables
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD_SET) begin
			weight_mem[set_idx_q] <= prio_q;
			length_mem[set_idx_q] <= fcount_q;
		end
	end

	// frame delay memory
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD_DELAY) begin
			delay_mem[{set_idx_q, frame_idx_q}] <= delay_q;
		end
		delay_rd_q <= delay_mem[{set_q, frame_q}];
	end

	assign current_set   = out_set_q;
	assign current_frame = out_frame_q;
	assign playing       = out_playing_q;
	assign frame_changed = out_changed_q;

endmodule

/* hw/rtl/sprite_animation_sequencer_core.sv */
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_core
// Flow: a request passes the decode state S_EXEC and then the output state S_OUT;
// a weighted pick adds the weight sum, a bit-serial remainder of the 16-bit
// random value by that sum and the cumulative weight walk between the two.
// Throughput: one request at a time, stalled in S_OUT until out_ready.
// Reset: playback stopped at set 0 frame 0, loop mode, one set; tables undefined.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_core
	import sas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [RND_W-1:0]      random_value,
	input  logic [SET_W-1:0]      set_index,
	input  logic [FRAME_W-1:0]    frame_index,
	input  logic [WEIGHT_W-1:0]   priority_req,
	input  logic [LEN_W-1:0]      frame_count,
	input  logic [DELAY_W-1:0]    delay_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SET_W-1:0]      current_set,
	output logic [FRAME_W-1:0]    current_frame,
	output logic                  playing,
	output logic                  frame_changed
);

	sas_ctl_t  ctl;
	sas_stat_t stat;

	assign cfg_ready = 1'b1;

	sas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	sas_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.now_ms        (now_ms),
		.random_value  (random_value),
		.set_index     (set_index),
		.frame_index   (frame_index),
		.priority_req  (priority_req),
		.frame_count   (frame_count),
		.delay_ms      (delay_ms),
		.current_set   (current_set),
		.current_frame (current_frame),
		.playing       (playing),
		.frame_changed (frame_changed)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in progress");

	a_stop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_changed && !playing |-> current_frame == '0)
		else $error("playback stopped by a tick without rewinding frame");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_DIV_INIT |-> !stat.sum_zero)
		else $error("remainder started with zero weight sum");

endmodule
